@@ sv/ptf_pkg.sv @@
package ptf_pkg;

	typedef enum logic [2:0] {
		MODE_I8   = 3'd0,
		MODE_I16  = 3'd1,
		MODE_I24  = 3'd2,
		MODE_I32  = 3'd3,
		MODE_PASS = 3'd4
	} mode_t;

	localparam logic [2:0] MODE_RESET = 3'd1;

	// leading one position of a 32-bit magnitude, priority search
	function automatic logic [4:0] msb_pos(input logic [31:0] v);
		logic [4:0] p;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) p = 5'(i);
		end
		return p;
	endfunction

endpackage

@@ sv/pcm_to_float_converter_top.sv @@
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | raw_sample, last_in
// out     | out_valid| out_stall | float_bits, last_out
// cfg     | cfg_we   | -         | cfg_data (sample_mode)
// one item per cycle while the output is not stalled, four register stages,
// stage 1 sign/magnitude, stage 2 leading one, stage 3 shift and round,
// stage 4 pack; the whole pipeline advances when the output is free or empty
// reset sets sample_mode to int16 and clears all valid bits
module pcm_to_float_converter_top
	import ptf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] raw_sample,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] float_bits,
	output logic        last_out
);

	logic [2:0] mode_q;
	logic       adv;
	logic       v_s1, v_s2, v_s3, v_s4;

	// stage payloads
	logic        zero_s1, neg_s1, pass_s1, last_s1;
	logic [31:0] mag_s1, raw_s1;
	logic [4:0]  scale_s1;
	logic        zero_s2, neg_s2, pass_s2, last_s2;
	logic [31:0] mag_s2, raw_s2;
	logic [4:0]  scale_s2, msb_s2;
	logic        zero_s3, neg_s3, pass_s3, last_s3;
	logic [31:0] raw_s3;
	logic [24:0] mant_s3;
	logic [7:0]  exp_s3;

	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= MODE_RESET;
		else if (cfg_we) mode_q <= cfg_data;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end
	assign out_valid = v_s4;

	// stage 1: mask, sign and magnitude
	logic [31:0] val_c;
	logic        neg_c, bad_c;
	logic [4:0]  scale_c;
	always_comb begin
		val_c = 32'd0; neg_c = 1'b0; scale_c = 5'd0; bad_c = 1'b0;
		case (mode_q)
			MODE_I8:  begin val_c = {{24{raw_sample[7]}},  raw_sample[7:0]};  scale_c = 5'd7;  end
			MODE_I16: begin val_c = {{16{raw_sample[15]}}, raw_sample[15:0]}; scale_c = 5'd15; end
			MODE_I24: begin val_c = {{8{raw_sample[23]}},  raw_sample[23:0]}; scale_c = 5'd23; end
			MODE_I32: begin val_c = raw_sample; scale_c = 5'd31; end
			MODE_PASS: ;
			default: bad_c = 1'b1;
		endcase
		neg_c = val_c[31];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s1  <= (val_c == 32'd0) || bad_c;
			neg_s1   <= neg_c;
			mag_s1   <= neg_c ? (~val_c + 32'd1) : val_c;
			scale_s1 <= scale_c;
			pass_s1  <= (mode_q == MODE_PASS);
			raw_s1   <= raw_sample;
			last_s1  <= last_in;
		end
	end

	// stage 2: leading one search
	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s2 <= zero_s1; neg_s2 <= neg_s1; mag_s2 <= mag_s1;
			scale_s2 <= scale_s1; pass_s2 <= pass_s1; raw_s2 <= raw_s1;
			last_s2 <= last_s1; msb_s2 <= msb_pos(mag_s1);
		end
	end

	// stage 3: normalise and round to nearest even
	logic [31:0] norm_c;
	logic [24:0] mant_c;
	logic        rnd_c;
	always_comb begin
		norm_c = mag_s2 << (5'd31 - msb_s2);
		rnd_c  = norm_c[7] && (norm_c[8] || (norm_c[6:0] != 7'd0));
		mant_c = {1'b0, norm_c[31:8]} + {24'd0, rnd_c};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			zero_s3 <= zero_s2; neg_s3 <= neg_s2; pass_s3 <= pass_s2;
			raw_s3 <= raw_s2; last_s3 <= last_s2; mant_s3 <= mant_c;
			exp_s3 <= 8'd127 + {3'd0, msb_s2} - {3'd0, scale_s2};
		end
	end

	// stage 4: pack the result word
	always_ff @(posedge clk) begin
		if (adv) begin
			last_out <= last_s3;
			if (pass_s3) float_bits <= raw_s3;
			else if (zero_s3) float_bits <= 32'd0;
			else if (mant_s3[24]) float_bits <= {neg_s3, exp_s3 + 8'd1, 23'd0};
			else float_bits <= {neg_s3, exp_s3, mant_s3[22:0]};
		end
	end

endmodule

@@ sv/ptf_checker.sv @@
module ptf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] float_bits,
	input logic        last_out
);

	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(float_bits) && $stable(last_out))
		else $error("result changed under stall");

	// input is held off only by a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");

	// an accepted item shows up once the pipeline has advanced it through every stage
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !in_stall ##1 !in_stall ##1 !in_stall |=> out_valid)
		else $error("item lost in pipeline");

endmodule

bind pcm_to_float_converter_top ptf_checker u_ptf_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .float_bits(float_bits),
	.last_out(last_out)
);

@@ test/pcm_to_float_converter_top_tb.sv @@
module pcm_to_float_converter_top_tb;
	import ptf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] raw_sample;
	logic        last_in;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] float_bits;
	logic        last_out;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} sample_out_t;

	// directed row: mode, sample, last, typed-in result if known
	typedef struct {
		logic [2:0]  mode;
		logic [31:0] raw;
		logic        last;
		logic        known;
		logic [31:0] word;
	} vec_row_t;

	sample_out_t float_q[$];
	logic [2:0]  cur_mode;
	int          mismatches;
	int          cycles;
	bit          hold_off;
	bit          timed_out;
	bit          stim_done;
	vec_row_t    vecs[$];

	pcm_to_float_converter_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .raw_sample(raw_sample),
		.last_in(last_in), .out_valid(out_valid), .out_stall(out_stall),
		.float_bits(float_bits), .last_out(last_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// signed sample of the given width, scaled to [-1, 1), round to nearest even
	function automatic logic [31:0] pcm_float(logic [31:0] raw, int bits);
		logic [32:0] v;
		logic [32:0] mag;
		logic [32:0] rem;
		logic [32:0] half;
		logic [32:0] mant;
		logic        neg;
		int          msb;
		int          r;
		logic [7:0]  expo;
		v = (bits == 32) ? {1'b0, raw} : ({1'b0, raw} & ((33'd1 << bits) - 33'd1));
		if (v == 33'd0) return 32'd0;
		neg = v[bits-1];
		mag = neg ? ((33'd1 << bits) - v) : v;
		msb = 0;
		for (int i = 0; i < 33; i++) if (mag[i]) msb = i;
		expo = 8'(127 + msb - (bits - 1));
		if (msb <= 23) begin
			mant = mag << (23 - msb);
		end else begin
			r = msb - 23;
			rem = mag & ((33'd1 << r) - 33'd1);
			half = 33'd1 << (r - 1);
			mant = mag >> r;
			if (rem > half || (rem == half && mant[0])) mant = mant + 33'd1;
			if (mant >= (33'd1 << 24)) begin
				mant = mant >> 1;
				expo = expo + 8'd1;
			end
		end
		return {neg, expo, mant[22:0]};
	endfunction

	function automatic logic [31:0] predict_word(logic [2:0] mode, logic [31:0] raw);
		case (mode)
			MODE_I8:   return pcm_float(raw, 8);
			MODE_I16:  return pcm_float(raw, 16);
			MODE_I24:  return pcm_float(raw, 24);
			MODE_I32:  return pcm_float(raw, 32);
			MODE_PASS: return raw;
			default:   return 32'd0;
		endcase
	endfunction

	task automatic add_row(logic [2:0] m, logic [31:0] r, logic l, logic k, logic [31:0] w);
		vec_row_t row;
		row.mode = m; row.raw = r; row.last = l; row.known = k; row.word = w;
		vecs.push_back(row);
	endtask

	// wait for the pipeline to drain, then write the mode register
	task automatic set_mode(logic [2:0] m);
		while (float_q.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = m;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_mode = m;
	endtask

	// offer one item and hold it until accepted
	task automatic send_sample(logic [31:0] r, logic l, logic k, logic [31:0] w);
		sample_out_t e;
		in_valid = 1'b1;
		raw_sample = r;
		last_in = l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		e.word = k ? w : predict_word(cur_mode, r);
		e.last = l;
		float_q.push_back(e);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_raw();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'h8000_0000 >> (8 * $urandom_range(0, 3));
			2: return 32'h7FFF_FFFF >> (8 * $urandom_range(0, 3));
			3: return 32'hFFFF_FFFF;
			4: return 32'(1) << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	// stimulus
	initial begin
		int burst;
		int gap;
		logic [2:0] modes[$];
		stim_done = 1'b0;
		cfg_we = 1'b0;
		cfg_data = MODE_RESET;
		in_valid = 1'b0;
		raw_sample = 32'd0;
		last_in = 1'b0;
		cur_mode = MODE_RESET;
		mismatches = 0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// reset mode is int16, then extremes of every width, pass-through and undefined modes
		add_row(MODE_I16, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000);
		add_row(MODE_I16, 32'hABCD_8000, 1'b1, 1'b1, 32'hBF80_0000);
		add_row(MODE_I16, 32'h0000_7FFF, 1'b0, 1'b0, 32'd0);
		add_row(MODE_I8,  32'hFFFF_FF80, 1'b1, 1'b1, 32'hBF80_0000);
		add_row(MODE_I8,  32'h1234_5600, 1'b0, 1'b1, 32'h0000_0000);
		add_row(MODE_I8,  32'h0000_007F, 1'b0, 1'b0, 32'd0);
		add_row(MODE_I8,  32'h0000_00FF, 1'b1, 1'b0, 32'd0);
		add_row(MODE_I24, 32'h0080_0000, 1'b0, 1'b1, 32'hBF80_0000);
		add_row(MODE_I24, 32'hFF7F_FFFF, 1'b1, 1'b0, 32'd0);
		add_row(MODE_I24, 32'h0000_0001, 1'b0, 1'b0, 32'd0);
		add_row(MODE_I32, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h3F80_0000);
		add_row(MODE_I32, 32'h8000_0000, 1'b1, 1'b1, 32'hBF80_0000);
		add_row(MODE_I32, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000);
		add_row(MODE_I32, 32'h0100_0001, 1'b0, 1'b0, 32'd0);
		add_row(MODE_I32, 32'h0100_0003, 1'b1, 1'b0, 32'd0);
		add_row(MODE_I32, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0);
		add_row(MODE_PASS, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'hDEAD_BEEF);
		add_row(MODE_PASS, 32'h7FC0_0000, 1'b0, 1'b1, 32'h7FC0_0000);
		add_row(3'd5, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000);
		add_row(3'd7, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000);

		foreach (vecs[i]) begin
			if (vecs[i].mode != cur_mode) set_mode(vecs[i].mode);
			send_sample(vecs[i].raw, vecs[i].last, vecs[i].known, vecs[i].word);
		end

		// random phases, extremes of the register among them
		modes = '{MODE_I8, MODE_I32, MODE_I16, MODE_PASS, MODE_I24, 3'd6, MODE_I32, MODE_I8};
		foreach (modes[p]) begin
			set_mode(modes[p]);
			if (p == 1) hold_off = 1'b1;
			for (int n = 0; n < 112; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < 112; b++, n++)
					send_sample(rand_raw(), 1'(($urandom_range(0, 7)) == 0), 1'b0, 32'd0);
				if ($urandom_range(0, 2) != 0) begin
					gap = $urandom_range(1, 6);
					repeat (gap) @(negedge clk);
				end
			end
		end
		stim_done = 1'b1;
	end

	// receiver stall pattern plus one long hold-off
	initial begin
		int hold;
		out_stall = 1'b0;
		hold_off = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall = 1'b1;
				for (hold = 0; hold < 60; hold++) @(negedge clk);
				hold_off = 1'b0;
				out_stall = 1'b0;
			end else if (cycles % 500 < 200) begin
				out_stall = 1'b0;
			end else begin
				out_stall = ($urandom_range(0, 3) == 0);
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		sample_out_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (float_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: float_bits %h last_out %b", float_bits, last_out);
			end else begin
				e = float_q.pop_front();
				if (float_bits !== e.word || last_out !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: float_bits %h exp %h, last_out %b exp %b",
							float_bits, e.word, last_out, e.last);
				end
			end
		end
	end

	// end of run and watchdog
	initial begin
		cycles = 0;
		timed_out = 1'b0;
		fork
			begin
				while (cycles < CYCLE_LIMIT) begin
					@(posedge clk);
					cycles++;
				end
				timed_out = 1'b1;
			end
			begin
				wait (stim_done);
				while (float_q.size() != 0) @(posedge clk);
				repeat (20) @(posedge clk);
			end
		join_any
		if (timed_out || float_q.size() != 0 || mismatches != 0) begin
			$display("pcm_to_float_converter_top_tb NOT OK");
		end else begin
			$display("pcm_to_float_converter_top_tb OK");
		end
		$finish;
	end

endmodule
